@@ rtl/oaht_pkg.sv @@
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // Table geometry. The slot count must be a power of two: the hash is
    // reduced to the low bits of the product.
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int KEY_W  = 16;

    // Hash multiplier.
    localparam int HASH_MUL = 9;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_SPARE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_GONE  = 2'd2,
        MARK_SPARE = 2'd3
    } mark_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;       // capture key, restart probing
        logic    issue;      // read the next slot of the probe sequence
        logic    wr_used;    // store key in the slot under test, mark it used
        logic    wr_gone;    // mark the slot under test deleted
        logic    res_load;   // capture the result beat
        status_t res_status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rd_vld;  // a probed slot is ready for evaluation
        logic free;    // probed slot is empty or deleted
        logic empty;   // probed slot is empty
        logic match;   // probed slot is used and holds the key
        logic last;    // probed slot is the final one of the sequence
    } dp_stat_t;

endpackage

@@ rtl/oaht_dpath.sv @@
// ----------------------------------------------------------------------------
// oaht_dpath
// Key store, slot marks, probe address generation and result register.
// ----------------------------------------------------------------------------
module oaht_dpath
    import oaht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [KEY_W-1:0]  in_key,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output status_t           res_status,
    output logic [SLOT_W-1:0] res_slot
);

    localparam int PROD_W = KEY_W + $clog2(HASH_MUL) + 1;

    logic [KEY_W-1:0]  key_mem [SLOTS];
    mark_t             marks_reg [SLOTS];

    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] base_reg;
    logic [SLOT_W-1:0] probe_reg;
    logic [SLOT_W-1:0] slot_q_reg;
    logic [SLOT_W-1:0] idx_q_reg;
    logic [KEY_W-1:0]  key_q_reg;
    mark_t             mark_q_reg;
    logic              rd_vld_reg;
    status_t           res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;

    logic [PROD_W-1:0] hash_prod;
    logic [SLOT_W-1:0] rd_addr;

    assign hash_prod = PROD_W'(in_key) * PROD_W'(HASH_MUL);
    assign rd_addr   = base_reg + probe_reg;

    // Probe control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            probe_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue;
            if (cmd.issue)
                probe_reg <= probe_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= in_key;
            base_reg <= hash_prod[SLOT_W-1:0];
        end
        if (cmd.issue)
        begin
            slot_q_reg <= rd_addr;
            idx_q_reg  <= probe_reg;
            mark_q_reg <= marks_reg[rd_addr];
        end
    end

    // Key store: written at the slot under test, read into key_q_reg on issue, ahead of the test
    always_ff @(posedge clk)
    begin
        if (cmd.wr_used)
            key_mem[slot_q_reg] <= key_reg;
        if (cmd.issue)
            key_q_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                marks_reg[i] <= MARK_EMPTY;
        end
        else if (cmd.wr_used)
            marks_reg[slot_q_reg] <= MARK_USED;
        else if (cmd.wr_gone)
            marks_reg[slot_q_reg] <= MARK_GONE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= (cmd.res_status == ST_DONE) ? slot_q_reg : '0;
        end
    end

    assign stat.rd_vld = rd_vld_reg;
    assign stat.free   = (mark_q_reg != MARK_USED);
    assign stat.empty  = (mark_q_reg == MARK_EMPTY);
    assign stat.match  = (mark_q_reg == MARK_USED) && (key_q_reg == key_reg);
    assign stat.last   = (idx_q_reg == SLOT_W'(SLOTS - 1));

    assign res_status = res_status_reg;
    assign res_slot   = res_slot_reg;

endmodule

@@ rtl/oaht_ctrl.sv @@
// ----------------------------------------------------------------------------
// oaht_ctrl
// Command sequencer: accepts a command, steps the probe and decides the end.
// ----------------------------------------------------------------------------
module oaht_ctrl
    import oaht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cmd_t     in_cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_PROBE  = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    cmd_t   op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cmd            = '0;
        cmd.res_status = ST_DONE;
        in_ready       = 1'b0;
        out_valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == CMD_NONE)
                    begin
                        // answer an unknown command without touching the table
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_MISSING;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        op_next    = in_cmd;
                        state_next = S_PROBE;
                    end
                end
            end

            S_PROBE:
            begin
                cmd.issue = 1'b1;
                if (stat.rd_vld)
                begin
                    if (op_reg == CMD_INSERT)
                    begin
                        if (stat.free)
                        begin
                            cmd.wr_used    = 1'b1;
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_DONE;
                            state_next     = S_RESULT;
                        end
                        else if (stat.last)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_RESULT;
                        end
                    end
                    else
                    begin
                        if (stat.match)
                        begin
                            cmd.wr_gone    = (op_reg == CMD_DELETE);
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_DONE;
                            state_next     = S_RESULT;
                        end
                        else if (stat.empty || stat.last)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_MISSING;
                            state_next     = S_RESULT;
                        end
                    end
                end
            end

            S_RESULT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/open_address_hash_table.sv @@
// ----------------------------------------------------------------------------
// open_address_hash_table
// Open-addressing hash table with linear probing from slot (9*key) mod SLOTS.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// s_*      in   tuser: command[1:0]; tdata: key[15:0]
// m_*      out  tuser: status[1:0]; tdata: slot[3:0], zero-padded to 8 bits
//
// A taken command probes up to SLOTS slots from its home slot; the probe
// loop reads one slot per cycle from the key store and the marks until it
// decides, and the result beat follows. No new command is taken meanwhile.
// An unknown command answers in the cycle after it is taken. Reset
// marks every slot empty at once. A stalled result beat holds the block;
// the next command is taken the cycle after the beat is taken.
// ----------------------------------------------------------------------------
module open_address_hash_table
    import oaht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // key[15:0]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // slot[3:0], zeros above
    output logic [1:0]  m_tuser    // status[1:0]
);

    dp_cmd_t           dp_cmd;
    dp_stat_t          dp_stat;
    status_t           res_status;
    logic [SLOT_W-1:0] res_slot;

    oaht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd_t'(s_tuser)),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    oaht_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_key     (s_tdata[KEY_W-1:0]),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .res_status (res_status),
        .res_slot   (res_slot)
    );

    assign m_tdata = {{(8 - SLOT_W){1'b0}}, res_slot};
    assign m_tuser = res_status;

endmodule

@@ sim/oaht_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_checker
// Watches both channels of the hash table, keeps its own copy of the slot
// keys and marks, works out the answer to every accepted command and checks
// each result beat against the oldest answer still due.
// ----------------------------------------------------------------------------
module oaht_checker
    import oaht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // key[15:0]
    input  logic [1:0]  s_tuser,   // command[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // slot[3:0], zeros above
    input  logic [1:0]  m_tuser,   // status[1:0]
    output int          errors,
    output int          pending
);

    typedef struct {
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } answer_t;

    mark_t            shadow_marks [SLOTS];
    logic [KEY_W-1:0] shadow_keys  [SLOTS];
    answer_t          answers_due  [$];
    int               shown = 0;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // Walk the probe sequence on the shadow copy and update it as the block would.
    function automatic answer_t resolve_command(input cmd_t cmd, input logic [KEY_W-1:0] key);
        answer_t     a;
        int unsigned origin;
        int unsigned s;
        a.cmd    = cmd;
        a.key    = key;
        a.status = ST_MISSING;
        a.slot   = '0;
        origin   = (HASH_MUL * key) % SLOTS;
        case (cmd)
            CMD_INSERT:
            begin
                a.status = ST_FULL;
                for (int p = 0; p < SLOTS; p++)
                begin
                    s = (origin + p) % SLOTS;
                    if (shadow_marks[s] != MARK_USED)
                    begin
                        shadow_keys[s]  = key;
                        shadow_marks[s] = MARK_USED;
                        a.status        = ST_DONE;
                        a.slot          = SLOT_W'(s);
                        break;
                    end
                end
            end
            CMD_SEARCH, CMD_DELETE:
            begin
                for (int p = 0; p < SLOTS; p++)
                begin
                    s = (origin + p) % SLOTS;
                    if (shadow_marks[s] == MARK_EMPTY)
                        break;
                    if (shadow_marks[s] == MARK_USED && shadow_keys[s] == key)
                    begin
                        // leave a tombstone so later probes carry on past it
                        if (cmd == CMD_DELETE)
                            shadow_marks[s] = MARK_GONE;
                        a.status = ST_DONE;
                        a.slot   = SLOT_W'(s);
                        break;
                    end
                end
            end
            default:
                ;
        endcase
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t due;
        if (!rst_n)
        begin
            foreach (shadow_marks[i])
                shadow_marks[i] = MARK_EMPTY;
            answers_due.delete();
            pending = 0;
        end
        else
        begin
            // Retire the result beat before taking a new command on the same edge.
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    errors++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("%0t: result beat with nothing due: status %0d tdata %h",
                                 $realtime, m_tuser, m_tdata);
                    end
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (m_tuser != due.status || m_tdata[SLOT_W-1:0] != due.slot
                        || m_tdata[7:SLOT_W] != '0)
                    begin
                        errors++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display("%0t: %s key %h: exp status %s slot %0d, got %0d tdata %h",
                                     $realtime, due.cmd.name(), due.key, due.status.name(),
                                     due.slot, m_tuser, m_tdata);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                answers_due.push_back(resolve_command(cmd_t'(s_tuser), s_tdata));
            pending = answers_due.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives insert, search and delete commands into the hash table: a directed
// run through empty, tombstoned and full tables, then phases of random
// commands over a small pool of colliding keys, with random idle bursts on
// both channels. The checker beside the block judges every result beat.
// ----------------------------------------------------------------------------
module tb;
    import oaht_pkg::*;

    localparam int PHASES    = 9;
    localparam int PHASE_LEN = 103;
    localparam int POOL_SIZE = 24;
    localparam int DRAIN_MAX = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // key[15:0]
    logic [1:0]  s_tuser;    // command[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // slot[3:0], zeros above
    logic [1:0]  m_tuser;    // status[1:0]
    int          errors;
    int          pending;

    // Odds of an idle burst per beat, 1 in N; zero turns idling off.
    int tx_odds = 3;
    int rx_odds = 3;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    open_address_hash_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    oaht_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_INSERT;
        m_tready <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Result side: hold tready low for random bursts.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall == 0 && rx_odds > 0 && $urandom_range(rx_odds - 1) == 0)
                stall = $urandom_range(1, 12);
            m_tready <= (stall == 0);
            if (stall > 0)
                stall--;
        end
    end

    task automatic send_command(input cmd_t cmd, input logic [KEY_W-1:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
        if (tx_odds > 0 && $urandom_range(tx_odds - 1) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    initial
    begin
        int   weight_insert;
        int   weight_search;
        int   roll;
        int   waited;
        cmd_t cmd;
        logic [KEY_W-1:0] key;

        wait (rst_n);
        @(posedge clk);

        // Keys three at a time, each 16 above the one before it: same home slot.
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i % 3 == 0) ? KEY_W'($urandom) : key_pool[i-1] + KEY_W'(16);

        // Extremes, a tombstone, an unknown command, then fill the table.
        send_command(CMD_INSERT, 16'h0000);
        send_command(CMD_INSERT, 16'hFFFF);
        send_command(CMD_SEARCH, 16'hFFFF);
        send_command(CMD_DELETE, 16'h0000);
        send_command(CMD_SEARCH, 16'h0000);
        send_command(CMD_DELETE, 16'h0000);
        send_command(CMD_NONE,   16'hA5A5);
        send_command(CMD_INSERT, 16'h0000);
        for (int i = 0; i < SLOTS - 2; i++)
            send_command(CMD_INSERT, key_pool[i]);
        send_command(CMD_INSERT, 16'h5A5A);
        send_command(CMD_SEARCH, 16'h1234);
        send_command(CMD_DELETE, 16'h4321);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Drain the full table first, then let the fill level wander.
            weight_insert = (ph == 0) ? 15 : $urandom_range(20, 60);
            weight_search = $urandom_range(15, 35);
            if (ph == PHASES - 1)
            begin
                tx_odds = 0;
                rx_odds = 0;
            end
            else
            begin
                tx_odds = (ph % 3 == 2) ? 0 : $urandom_range(2, 8);
                rx_odds = (ph % 4 == 3) ? 0 : $urandom_range(2, 8);
            end
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                roll = $urandom_range(99);
                if (roll < weight_insert)
                    cmd = CMD_INSERT;
                else if (roll < weight_insert + weight_search)
                    cmd = CMD_SEARCH;
                else if (roll < 95)
                    cmd = CMD_DELETE;
                else
                    cmd = CMD_NONE;
                if ($urandom_range(9) < 7)
                    key = key_pool[$urandom_range(POOL_SIZE - 1)];
                else
                    key = KEY_W'($urandom);
                send_command(cmd, key);
            end
        end
        s_tvalid <= 1'b0;

        // let the checker log the last accepted command before polling it
        @(posedge clk);
        for (waited = 0; pending != 0 && waited < DRAIN_MAX; waited++)
            @(posedge clk);
        if (pending != 0)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            repeat (SLOTS + 8) @(posedge clk);
            if (errors == 0)
                $display("PASS");
            else
                $display("FAIL");
            $finish;
        end
    end

endmodule

@@ files.f @@
rtl/oaht_pkg.sv
rtl/oaht_dpath.sv
rtl/oaht_ctrl.sv
rtl/open_address_hash_table.sv
sim/oaht_checker.sv
sim/tb.sv
